@@ src/pal_pkg.sv @@
// ----------------------------------------------------------------------------
// pal_pkg: shared definitions for the positional array list
// Sizes, operation codes and status codes used by the list controller; its
// entry memory takes its depth and width from these sizes.
// ----------------------------------------------------------------------------
package pal_pkg;

  // List geometry. The field widths of the interface fix these values.
  localparam int CAPACITY = 128;
  localparam int ADDR_W   = 7;   // index of one entry
  localparam int CNT_W    = 8;   // entry count, 0 to CAPACITY
  localparam int DATA_W   = 32;

  // Operation codes carried on in_op.
  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_SEARCH = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  // Status codes carried on out_status.
  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_FULL     = 3'd1;
  localparam logic [2:0] STS_EMPTY    = 3'd2;
  localparam logic [2:0] STS_INVALID  = 3'd3;
  localparam logic [2:0] STS_NOTFOUND = 3'd4;

endpackage

@@ src/positional_array_list.sv @@
// ----------------------------------------------------------------------------
// positional_array_list: packed ordered list of signed 32-bit values
// Clear, insert, delete, search and read on a list of up to 128 entries that
// live in one synchronous RAM.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and exactly one
// result follows, shown for a single cycle with out_valid high; the receiver
// cannot stall it, so it must take every result in that cycle. Clear, every
// rejected request (full, empty, invalid position) and unused op codes answer
// in the cycle after the request, and busy stays low. Every other request
// raises busy; its result is shown in the same cycle as busy falls. A read
// raises busy while the RAM returns the entry, so its result comes later than
// a clear's. The entries sit in a RAM with one read and one write port, and
// the shifting and scanning go through it one entry per cycle: an insert at
// position p moves each entry from p up to count - 1 one slot up, a delete
// moves each entry above p one slot down, and a search compares entries from
// index 0 until the first match or the end of the list; an insert at the
// tail or a delete of the last entry shifts nothing. The result is registered,
// so a new request may be taken in the very cycle its predecessor's result
// is shown.
// ----------------------------------------------------------------------------
module positional_array_list (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_position,
  input  logic signed [31:0] in_value,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [6:0]  out_found_index,
  output logic signed [31:0] out_read_value,
  output logic [7:0]  out_count
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_DEL  = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;

  localparam logic [pal_pkg::CNT_W-1:0] CAP = pal_pkg::CNT_W'(pal_pkg::CAPACITY);

  logic [2:0]                   state_r, state_nxt;
  logic [pal_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [pal_pkg::CNT_W-1:0]    ptr_r, ptr_nxt;
  logic [pal_pkg::CNT_W-1:0]    pos_r, pos_nxt;
  logic [pal_pkg::DATA_W-1:0]   val_r, val_nxt;
  logic                         pend_r, pend_nxt;
  logic [pal_pkg::ADDR_W-1:0]   waddr_r, waddr_nxt;

  logic                         ov_r, ov_nxt;
  logic [2:0]                   ost_r, ost_nxt;
  logic [pal_pkg::ADDR_W-1:0]   ofi_r, ofi_nxt;
  logic [pal_pkg::DATA_W-1:0]   ord_r, ord_nxt;
  logic [pal_pkg::CNT_W-1:0]    ocnt_r, ocnt_nxt;

  logic                         mem_we;
  logic [pal_pkg::ADDR_W-1:0]   mem_waddr;
  logic [pal_pkg::DATA_W-1:0]   mem_wdata;
  logic [pal_pkg::ADDR_W-1:0]   mem_raddr;
  logic [pal_pkg::DATA_W-1:0]   mem_rdata;

  logic [pal_pkg::CNT_W-1:0]    ptr_dec;
  logic [pal_pkg::CNT_W-1:0]    ptr_inc;

  assign ptr_dec = ptr_r - 1'b1;
  assign ptr_inc = ptr_r + 1'b1;

  pal_ram #(
    .DEPTH (pal_pkg::CAPACITY),
    .WIDTH (pal_pkg::DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The sequencer streams the list through the RAM. A read issued in one
  // cycle returns in the next, where pend_r marks it and waddr_r holds the
  // entry it belongs to: the slot above it for an insert, the slot below it
  // for a delete, or its own index for a search. A read and a write in the
  // same cycle never touch the same entry, so no forwarding is needed.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    pend_nxt  = 1'b0;
    waddr_nxt = waddr_r;
    ov_nxt    = 1'b0;
    ost_nxt   = ost_r;
    ofi_nxt   = ofi_r;
    ord_nxt   = ord_r;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          pos_nxt = in_position;
          val_nxt = in_value;
          ost_nxt = pal_pkg::STS_OK;
          ofi_nxt = '0;
          ord_nxt = '0;
          unique case (in_op)
            pal_pkg::OP_CLEAR: begin
              count_nxt = '0;
              ov_nxt    = 1'b1;
            end
            pal_pkg::OP_INSERT: begin
              if (count_r == CAP) begin
                ost_nxt = pal_pkg::STS_FULL;
                ov_nxt  = 1'b1;
              end else if (in_position > count_r) begin
                ost_nxt = pal_pkg::STS_INVALID;
                ov_nxt  = 1'b1;
              end else begin
                ptr_nxt   = count_r;
                state_nxt = S_INS;
              end
            end
            pal_pkg::OP_DELETE: begin
              if (count_r == '0) begin
                ost_nxt = pal_pkg::STS_EMPTY;
                ov_nxt  = 1'b1;
              end else if (in_position >= count_r) begin
                ost_nxt = pal_pkg::STS_INVALID;
                ov_nxt  = 1'b1;
              end else begin
                ptr_nxt   = in_position + 1'b1;
                state_nxt = S_DEL;
              end
            end
            pal_pkg::OP_SEARCH: begin
              ptr_nxt   = '0;
              state_nxt = S_SRCH;
            end
            pal_pkg::OP_READ: begin
              if (in_position >= count_r) begin
                ost_nxt = pal_pkg::STS_INVALID;
                ov_nxt  = 1'b1;
              end else begin
                mem_raddr = in_position[pal_pkg::ADDR_W-1:0];
                state_nxt = S_RD;
              end
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end

      S_INS: begin
        // Walk down from the top, moving each entry one slot up, then drop
        // the new value into the freed slot.
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = waddr_r;
          mem_wdata = mem_rdata;
        end
        if (ptr_r > pos_r) begin
          mem_raddr = ptr_dec[pal_pkg::ADDR_W-1:0];
          waddr_nxt = ptr_r[pal_pkg::ADDR_W-1:0];
          pend_nxt  = 1'b1;
          ptr_nxt   = ptr_dec;
        end else if (!pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pos_r[pal_pkg::ADDR_W-1:0];
          mem_wdata = val_r;
          count_nxt = count_r + 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_DEL: begin
        // Walk up from just above the removed entry, moving each one down.
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = waddr_r;
          mem_wdata = mem_rdata;
        end
        if (ptr_r < count_r) begin
          mem_raddr = ptr_r[pal_pkg::ADDR_W-1:0];
          waddr_nxt = ptr_dec[pal_pkg::ADDR_W-1:0];
          pend_nxt  = 1'b1;
          ptr_nxt   = ptr_inc;
        end else if (!pend_r) begin
          count_nxt = count_r - 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_SRCH: begin
        // Reads run one ahead of the compare; the first hit ends the scan.
        if (pend_r && (mem_rdata == val_r)) begin
          ofi_nxt   = waddr_r;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else if (ptr_r < count_r) begin
          mem_raddr = ptr_r[pal_pkg::ADDR_W-1:0];
          waddr_nxt = ptr_r[pal_pkg::ADDR_W-1:0];
          pend_nxt  = 1'b1;
          ptr_nxt   = ptr_inc;
        end else if (!pend_r) begin
          ost_nxt   = pal_pkg::STS_NOTFOUND;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_RD: begin
        ord_nxt   = mem_rdata;
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    ocnt_nxt = ov_nxt ? count_nxt : ocnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    pos_r   <= pos_nxt;
    val_r   <= val_nxt;
    waddr_r <= waddr_nxt;
    ost_r   <= ost_nxt;
    ofi_r   <= ofi_nxt;
    ord_r   <= ord_nxt;
    ocnt_r  <= ocnt_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_found_index = ofi_r;
  assign out_read_value  = ord_r;
  assign out_count       = ocnt_r;

  // The list never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP)
    else $error("entry count beyond capacity");

  // A clear answers in the next cycle with an empty list.
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == pal_pkg::OP_CLEAR) |=> (out_valid && out_count == '0))
    else $error("clear did not answer with an empty list");

  // A full report always comes with a full list.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == pal_pkg::STS_FULL) |-> (out_count == CAP))
    else $error("full reported on a list that is not full");

  // A result only follows an operation that was running or just accepted.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result without a request");

  // A read that ran in the RAM reports success.
  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |=> (out_valid && out_status == pal_pkg::STS_OK && !busy))
    else $error("read did not complete");

endmodule

@@ src/pal_ram.sv @@
// ----------------------------------------------------------------------------
// pal_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered, so it appears
// in the cycle after the address.
// ----------------------------------------------------------------------------
module pal_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
